>>> hdl/cht_pkg.sv
// cht_pkg: shared types and codes for the chained hash table
// no dependencies; used by cht_mod and chained_hash_table
`timescale 1ns / 1ps

package cht_pkg;

    localparam int KEY_W = 31;
    localparam int VAL_W = 31;

    typedef logic [1:0]       func_t;
    typedef logic [1:0]       status_t;
    typedef logic [KEY_W-1:0] key_t;
    typedef logic [VAL_W-1:0] value_t;

    localparam func_t FUNC_INSERT = 2'd0;
    localparam func_t FUNC_SEARCH = 2'd1;
    localparam func_t FUNC_REMOVE = 2'd2;
    localparam func_t FUNC_NONE   = 2'd3;

    localparam status_t ST_OK        = 2'd0;
    localparam status_t ST_NOT_FOUND = 2'd1;
    localparam status_t ST_DUPLICATE = 2'd2;
    localparam status_t ST_FULL      = 2'd3;

    typedef struct packed {
        key_t   key;
        value_t value;
    } node_kv_t;

endpackage

>>> hdl/cht_ram.sv
// cht_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies
`timescale 1ns / 1ps

module cht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> hdl/cht_mod.sv
// cht_mod: key modulo bucket count, eight key bits per cycle
// depends on cht_pkg
`timescale 1ns / 1ps

module cht_mod #(
    parameter int DIVISOR = 7,
    parameter int REM_W   = 3
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  cht_pkg::key_t     key,
    output logic              done,
    output logic [REM_W-1:0]  rem
);

    localparam int RW         = $clog2(DIVISOR) + 1;
    localparam int DIGIT_W    = 8;
    localparam int NUM_DIGITS = (cht_pkg::KEY_W + DIGIT_W - 1) / DIGIT_W;
    localparam int PAD_W      = NUM_DIGITS * DIGIT_W;
    localparam int CNT_W      = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;

    logic [PAD_W-1:0] shift_reg, shift_next;
    logic [RW-1:0]    rem_reg, rem_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             active_reg, active_next;
    logic             done_reg, done_next;
    logic [RW-1:0]    r;

    always_comb
    begin
        r = rem_reg;
        for (int i = 0; i < DIGIT_W; i++)
        begin
            r = (r << 1) | RW'(shift_reg[PAD_W-1-i]);
            if (r >= RW'(DIVISOR))
            begin
                r = r - RW'(DIVISOR);
            end
        end
    end

    always_comb
    begin
        shift_next  = shift_reg;
        rem_next    = rem_reg;
        cnt_next    = cnt_reg;
        active_next = active_reg;
        done_next   = 1'b0;
        if (start)
        begin
            shift_next  = PAD_W'(key);
            rem_next    = '0;
            cnt_next    = '0;
            active_next = 1'b1;
        end
        else if (active_reg)
        begin
            shift_next = shift_reg << DIGIT_W;
            rem_next   = r;
            cnt_next   = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(NUM_DIGITS - 1))
            begin
                active_next = 1'b0;
                done_next   = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            done_reg   <= 1'b0;
            cnt_reg    <= '0;
        end
        else
        begin
            active_reg <= active_next;
            done_reg   <= done_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
        rem_reg   <= rem_next;
    end

    assign done = done_reg;
    assign rem  = REM_W'(rem_reg);

endmodule

>>> hdl/chained_hash_table.sv
// chained_hash_table: key to value table with separate chaining, top level
// depends on cht_pkg, cht_ram, cht_mod
`timescale 1ns / 1ps
//
// usage:
//   a request (func, key, item_value) is taken at a clock edge with start high and
//   busy low. func selects insert, search or remove. exactly one result follows:
//   done is high for one cycle with status and found_value valid in that cycle.
//   the receiver cannot stall; the result is gone after that cycle.
//   the steps are the key modulo (8 key bits per cycle), a read and test of the
//   bucket head, one compare per chain node, and for a successful insert or
//   remove two write states (S_INS_WR1/2 or S_REM_WR1/2). a new request is not
//   taken until the last one is done. each node costs one read of the node memories.
//   busy falls as done rises, so a new request can be given in the done cycle.
//   after reset the link memory is swept once to build the free list and empty
//   all buckets, with busy high.
//   func code 3 is answered with ok in the cycle after it is taken.
//

module chained_hash_table #(
    parameter int NUM_BUCKETS = 7,
    parameter int POOL_SIZE   = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  cht_pkg::func_t     func,
    input  cht_pkg::key_t      key,
    input  cht_pkg::value_t    item_value,
    output logic               busy,
    output logic               done,
    output cht_pkg::status_t   status,
    output cht_pkg::value_t    found_value
);

    localparam int NW     = $clog2(POOL_SIZE + 1);
    localparam int NAW    = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
    localparam int BW     = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
    localparam int LDEPTH = POOL_SIZE + NUM_BUCKETS;
    localparam int LAW    = $clog2(LDEPTH);
    localparam logic [NW-1:0] NIL = NW'(POOL_SIZE);

    localparam logic [3:0] S_INIT    = 4'd0;
    localparam logic [3:0] S_IDLE    = 4'd1;
    localparam logic [3:0] S_MOD     = 4'd2;
    localparam logic [3:0] S_HEAD    = 4'd3;
    localparam logic [3:0] S_WALK    = 4'd4;
    localparam logic [3:0] S_CMP     = 4'd5;
    localparam logic [3:0] S_INS_WR1 = 4'd6;
    localparam logic [3:0] S_INS_WR2 = 4'd7;
    localparam logic [3:0] S_REM_WR1 = 4'd8;
    localparam logic [3:0] S_REM_WR2 = 4'd9;

    logic [3:0]            state_reg, state_next;
    logic [LAW-1:0]        init_reg, init_next;
    logic [NW-1:0]         free_head_reg, free_head_next;
    logic [NW-1:0]         cur_reg, cur_next;
    logic [NW-1:0]         next_hit_reg, next_hit_next;
    logic [LAW-1:0]        prev_reg, prev_next;
    cht_pkg::func_t        func_reg, func_next;
    cht_pkg::key_t         key_reg, key_next;
    cht_pkg::value_t       val_reg, val_next;
    logic                  done_reg, done_next;
    cht_pkg::status_t      status_reg, status_next;
    cht_pkg::value_t       found_reg, found_next;

    logic                  mod_start;
    logic                  mod_done;
    logic [BW-1:0]         mod_rem;

    logic                  link_we;
    logic [LAW-1:0]        link_waddr, link_raddr;
    logic [NW-1:0]         link_wdata, link_rdata;
    logic                  kv_we;
    logic [NAW-1:0]        kv_waddr, kv_raddr;
    cht_pkg::node_kv_t     kv_wdata, kv_rdata;
    logic [LAW-1:0]        walk_prev;

    cht_mod #(
        .DIVISOR (NUM_BUCKETS),
        .REM_W   (BW)
    ) u_mod (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mod_start),
        .key   (key),
        .done  (mod_done),
        .rem   (mod_rem)
    );

    // node links at 0..POOL_SIZE-1, bucket heads above them
    cht_ram #(
        .WIDTH (NW),
        .DEPTH (LDEPTH)
    ) u_link_ram (
        .clk   (clk),
        .we    (link_we),
        .waddr (link_waddr),
        .wdata (link_wdata),
        .raddr (link_raddr),
        .rdata (link_rdata)
    );

    cht_ram #(
        .WIDTH ($bits(cht_pkg::node_kv_t)),
        .DEPTH (POOL_SIZE)
    ) u_kv_ram (
        .clk   (clk),
        .we    (kv_we),
        .waddr (kv_waddr),
        .wdata (kv_wdata),
        .raddr (kv_raddr),
        .rdata (kv_rdata)
    );

    assign walk_prev = (state_reg == S_CMP) ? LAW'(cur_reg) : prev_reg;

    always_comb
    begin
        state_next     = state_reg;
        init_next      = init_reg;
        free_head_next = free_head_reg;
        cur_next       = cur_reg;
        next_hit_next  = next_hit_reg;
        prev_next      = prev_reg;
        func_next      = func_reg;
        key_next       = key_reg;
        val_next       = val_reg;
        done_next      = 1'b0;
        status_next    = status_reg;
        found_next     = found_reg;
        mod_start      = 1'b0;
        link_we        = 1'b0;
        link_waddr     = '0;
        link_wdata     = '0;
        link_raddr     = '0;
        kv_we          = 1'b0;
        kv_waddr       = '0;
        kv_wdata       = '0;
        kv_raddr       = '0;

        case (state_reg)
            S_INIT:
            begin
                link_we    = 1'b1;
                link_waddr = init_reg;
                link_wdata = (init_reg < LAW'(POOL_SIZE)) ? NW'(init_reg + 1'b1) : NIL;
                init_next  = init_reg + 1'b1;
                if (init_reg == LAW'(LDEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    func_next = func;
                    key_next  = key;
                    val_next  = item_value;
                    if (func == cht_pkg::FUNC_NONE)
                    begin
                        done_next   = 1'b1;
                        status_next = cht_pkg::ST_OK;
                        found_next  = '0;
                    end
                    else
                    begin
                        mod_start  = 1'b1;
                        state_next = S_MOD;
                    end
                end
            end
            S_MOD:
            begin
                if (mod_done)
                begin
                    state_next = S_HEAD;
                end
            end
            S_HEAD:
            begin
                link_raddr = LAW'(POOL_SIZE) + LAW'(mod_rem);
                prev_next  = LAW'(POOL_SIZE) + LAW'(mod_rem);
                state_next = S_WALK;
            end
            S_WALK, S_CMP:
            begin
                if (state_reg == S_CMP && kv_rdata.key == key_reg)
                begin
                    // hit on cur_reg, prev_reg points at it
                    found_next = '0;
                    case (func_reg)
                        cht_pkg::FUNC_INSERT:
                        begin
                            status_next = cht_pkg::ST_DUPLICATE;
                            done_next   = 1'b1;
                            state_next  = S_IDLE;
                        end
                        cht_pkg::FUNC_SEARCH:
                        begin
                            status_next = cht_pkg::ST_OK;
                            found_next  = kv_rdata.value;
                            done_next   = 1'b1;
                            state_next  = S_IDLE;
                        end
                        default:
                        begin
                            next_hit_next = link_rdata;
                            state_next    = S_REM_WR1;
                        end
                    endcase
                end
                else
                begin
                    prev_next = walk_prev;
                    if (link_rdata == NIL)
                    begin
                        // miss, walk_prev is the tail link
                        found_next = '0;
                        if (func_reg != cht_pkg::FUNC_INSERT)
                        begin
                            status_next = cht_pkg::ST_NOT_FOUND;
                            done_next   = 1'b1;
                            state_next  = S_IDLE;
                        end
                        else if (free_head_reg == NIL)
                        begin
                            status_next = cht_pkg::ST_FULL;
                            done_next   = 1'b1;
                            state_next  = S_IDLE;
                        end
                        else
                        begin
                            link_raddr = LAW'(free_head_reg);
                            state_next = S_INS_WR1;
                        end
                    end
                    else
                    begin
                        cur_next   = link_rdata;
                        link_raddr = LAW'(link_rdata);
                        kv_raddr   = NAW'(link_rdata);
                        state_next = S_CMP;
                    end
                end
            end
            S_INS_WR1:
            begin
                free_head_next = link_rdata;
                cur_next       = free_head_reg;
                kv_we          = 1'b1;
                kv_waddr       = NAW'(free_head_reg);
                kv_wdata.key   = key_reg;
                kv_wdata.value = val_reg;
                link_we        = 1'b1;
                link_waddr     = LAW'(free_head_reg);
                link_wdata     = NIL;
                state_next     = S_INS_WR2;
            end
            S_INS_WR2:
            begin
                link_we     = 1'b1;
                link_waddr  = prev_reg;
                link_wdata  = cur_reg;
                status_next = cht_pkg::ST_OK;
                done_next   = 1'b1;
                state_next  = S_IDLE;
            end
            S_REM_WR1:
            begin
                link_we    = 1'b1;
                link_waddr = prev_reg;
                link_wdata = next_hit_reg;
                state_next = S_REM_WR2;
            end
            S_REM_WR2:
            begin
                link_we        = 1'b1;
                link_waddr     = LAW'(cur_reg);
                link_wdata     = free_head_reg;
                free_head_next = cur_reg;
                status_next    = cht_pkg::ST_OK;
                done_next      = 1'b1;
                state_next     = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            init_reg      <= '0;
            free_head_reg <= '0;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            init_reg      <= init_next;
            free_head_reg <= free_head_next;
            done_reg      <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg      <= cur_next;
        next_hit_reg <= next_hit_next;
        prev_reg     <= prev_next;
        func_reg     <= func_next;
        key_reg      <= key_next;
        val_reg      <= val_next;
        status_reg   <= status_next;
        found_reg    <= found_next;
    end

    assign busy        = (state_reg != S_IDLE);
    assign done        = done_reg;
    assign status      = status_reg;
    assign found_value = found_reg;

endmodule

>>> tb/tb_top.sv
// tb_top: self-checking testbench for chained_hash_table (insert, search, remove requests)
// depends on cht_pkg and chained_hash_table; keeps its own copy of the table to predict results
`timescale 1ns / 1ps

module tb_top;

    localparam int NUM_BUCKETS  = 7;
    localparam int POOL_SIZE    = 64;
    localparam int KEY_POOL     = 100;
    localparam int DRAIN_CYCLES = 100;
    localparam int TIMEOUT_NS   = 1000000;

    typedef logic [6:0] idx_t;
    localparam idx_t NIL = idx_t'(POOL_SIZE);

    typedef struct packed {
        cht_pkg::status_t status;
        cht_pkg::value_t  value;
    } result_t;

    logic             clk = 1'b0;
    logic             rst_n;
    logic             start;
    cht_pkg::func_t   func;
    cht_pkg::key_t    key;
    cht_pkg::value_t  item_value;
    logic             busy;
    logic             done;
    cht_pkg::status_t status;
    cht_pkg::value_t  found_value;

    // shadow copy of the table
    idx_t             tbl_head [NUM_BUCKETS];
    cht_pkg::key_t    tbl_key  [POOL_SIZE];
    cht_pkg::value_t  tbl_value[POOL_SIZE];
    idx_t             tbl_next [POOL_SIZE];
    idx_t             tbl_free;

    result_t          pending_results[$];
    cht_pkg::key_t    key_pool[KEY_POOL];
    int               error_count = 0;
    int               gap_pct = 0;

    chained_hash_table #(
        .NUM_BUCKETS(NUM_BUCKETS),
        .POOL_SIZE  (POOL_SIZE)
    ) uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .func       (func),
        .key        (key),
        .item_value (item_value),
        .busy       (busy),
        .done       (done),
        .status     (status),
        .found_value(found_value)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic void table_clear();
        for (int i = 0; i < NUM_BUCKETS; i++)
            tbl_head[i] = NIL;
        for (int i = 0; i < POOL_SIZE; i++)
        begin
            tbl_key[i]   = '0;
            tbl_value[i] = '0;
            tbl_next[i]  = (i + 1 < POOL_SIZE) ? idx_t'(i + 1) : NIL;
        end
        tbl_free = '0;
    endfunction

    // applies one request to the shadow table and returns the result it causes
    function automatic result_t table_apply(cht_pkg::func_t f, cht_pkg::key_t k,
                                            cht_pkg::value_t v);
        result_t    r;
        logic [2:0] bucket;
        idx_t       p;
        idx_t       prev;
        idx_t       tail;
        idx_t       hit;
        idx_t       n;
        int         steps;
        r.status = cht_pkg::ST_OK;
        r.value  = '0;
        bucket   = 3'(k % NUM_BUCKETS);
        p        = tbl_head[bucket];
        prev     = NIL;
        tail     = NIL;
        hit      = NIL;
        steps    = 0;
        while (p != NIL && steps < POOL_SIZE && hit == NIL)
        begin
            if (tbl_key[p[5:0]] == k)
                hit = p;
            else
            begin
                tail = p;
                prev = p;
                p    = tbl_next[p[5:0]];
                steps++;
            end
        end
        case (f)
            cht_pkg::FUNC_INSERT:
            begin
                if (hit != NIL)
                    r.status = cht_pkg::ST_DUPLICATE;
                else if (tbl_free == NIL)
                    r.status = cht_pkg::ST_FULL;
                else
                begin
                    n                  = tbl_free;
                    tbl_free           = tbl_next[n[5:0]];
                    tbl_key[n[5:0]]    = k;
                    tbl_value[n[5:0]]  = v;
                    tbl_next[n[5:0]]   = NIL;
                    if (tail != NIL)
                        tbl_next[tail[5:0]] = n;
                    else
                        tbl_head[bucket] = n;
                end
            end
            cht_pkg::FUNC_SEARCH:
            begin
                if (hit != NIL)
                    r.value = tbl_value[hit[5:0]];
                else
                    r.status = cht_pkg::ST_NOT_FOUND;
            end
            cht_pkg::FUNC_REMOVE:
            begin
                if (hit != NIL)
                begin
                    if (prev != NIL)
                        tbl_next[prev[5:0]] = tbl_next[hit[5:0]];
                    else
                        tbl_head[bucket] = tbl_next[hit[5:0]];
                    tbl_next[hit[5:0]] = tbl_free;
                    tbl_free           = hit;
                end
                else
                    r.status = cht_pkg::ST_NOT_FOUND;
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    // leaves start high on return so back-to-back requests need no extra edge
    task automatic send_request(cht_pkg::func_t f, cht_pkg::key_t k, cht_pkg::value_t v);
        if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 20)) @(posedge clk);
        end
        start      <= 1'b1;
        func       <= f;
        key        <= k;
        item_value <= v;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        pending_results.push_back(table_apply(f, k, v));
    endtask

    task automatic wait_drain();
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        result_t exp_r;
        if (rst_n === 1'b1 && done === 1'b1)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result expected none actual status %0d value %0d",
                         $time, status, found_value);
                error_count++;
            end
            else
            begin
                exp_r = pending_results.pop_front();
                if (status !== exp_r.status)
                begin
                    $display("%0t: status mismatch expected %0d actual %0d",
                             $time, exp_r.status, status);
                    error_count++;
                end
                if (found_value !== exp_r.value)
                begin
                    $display("%0t: found_value mismatch expected %0d actual %0d",
                             $time, exp_r.value, found_value);
                    error_count++;
                end
            end
        end
    end

    task automatic test_directed_ops();
        cht_pkg::key_t   kmax;
        cht_pkg::value_t vmax;
        kmax = '1;
        vmax = '1;
        gap_pct = 0;
        send_request(cht_pkg::FUNC_INSERT, '0, '0);
        send_request(cht_pkg::FUNC_INSERT, kmax, vmax);
        send_request(cht_pkg::FUNC_SEARCH, '0, vmax);
        send_request(cht_pkg::FUNC_SEARCH, kmax, '0);
        // duplicate insert
        send_request(cht_pkg::FUNC_INSERT, '0, vmax);
        // misses in an occupied bucket
        send_request(cht_pkg::FUNC_SEARCH, cht_pkg::key_t'(7), '0);
        send_request(cht_pkg::FUNC_REMOVE, cht_pkg::key_t'(14), '0);
        // remove head node
        send_request(cht_pkg::FUNC_REMOVE, '0, '0);
        send_request(cht_pkg::FUNC_SEARCH, '0, '0);
        send_request(cht_pkg::FUNC_NONE, kmax, vmax);
        send_request(cht_pkg::FUNC_INSERT, cht_pkg::key_t'(7),
                     cht_pkg::value_t'(31'h2aaa_aaaa));
        send_request(cht_pkg::FUNC_INSERT, cht_pkg::key_t'(14),
                     cht_pkg::value_t'(31'h5555_5555));
        send_request(cht_pkg::FUNC_INSERT, cht_pkg::key_t'(21), cht_pkg::value_t'(21));
        // middle and tail nodes
        send_request(cht_pkg::FUNC_REMOVE, cht_pkg::key_t'(14), '0);
        send_request(cht_pkg::FUNC_SEARCH, cht_pkg::key_t'(21), '0);
        send_request(cht_pkg::FUNC_REMOVE, cht_pkg::key_t'(21), '0);
        send_request(cht_pkg::FUNC_SEARCH, cht_pkg::key_t'(7), '0);
        send_request(cht_pkg::FUNC_REMOVE, cht_pkg::key_t'(7), '0);
        send_request(cht_pkg::FUNC_REMOVE, kmax, '0);
        send_request(cht_pkg::FUNC_SEARCH, kmax, '0);
        send_request(cht_pkg::FUNC_NONE, '0, '0);
        wait_drain();
    endtask

    // one bucket takes the whole pool, so chains run to full length
    task automatic test_pool_exhaust();
        gap_pct = 0;
        for (int i = 0; i < POOL_SIZE; i++)
            send_request(cht_pkg::FUNC_INSERT, cht_pkg::key_t'(7 * i + 3),
                         cht_pkg::value_t'($urandom));
        send_request(cht_pkg::FUNC_INSERT, cht_pkg::key_t'(7 * POOL_SIZE + 3),
                     cht_pkg::value_t'($urandom));
        send_request(cht_pkg::FUNC_INSERT, cht_pkg::key_t'(3), cht_pkg::value_t'($urandom));
        send_request(cht_pkg::FUNC_SEARCH, cht_pkg::key_t'(7 * (POOL_SIZE - 1) + 3), '0);
        send_request(cht_pkg::FUNC_SEARCH, cht_pkg::key_t'(7 * POOL_SIZE + 3), '0);
        send_request(cht_pkg::FUNC_REMOVE, cht_pkg::key_t'(7 * (POOL_SIZE - 1) + 3), '0);
        send_request(cht_pkg::FUNC_INSERT, cht_pkg::key_t'(7 * POOL_SIZE + 3),
                     cht_pkg::value_t'($urandom));
        send_request(cht_pkg::FUNC_SEARCH, cht_pkg::key_t'(7 * POOL_SIZE + 3), '0);
        send_request(cht_pkg::FUNC_REMOVE, cht_pkg::key_t'(3), '0);
        send_request(cht_pkg::FUNC_REMOVE, cht_pkg::key_t'(7 * 30 + 3), '0);
        send_request(cht_pkg::FUNC_INSERT, cht_pkg::key_t'(3), cht_pkg::value_t'($urandom));
        for (int i = 0; i <= POOL_SIZE; i++)
            send_request(cht_pkg::FUNC_REMOVE, cht_pkg::key_t'(7 * i + 3), '0);
        send_request(cht_pkg::FUNC_SEARCH, cht_pkg::key_t'(3), '0);
        wait_drain();
    endtask

    task automatic test_random_mix(int count, int idle_pct);
        int             r;
        bit             fill_bias;
        cht_pkg::func_t f;
        cht_pkg::key_t  k;
        gap_pct   = idle_pct;
        fill_bias = 1'b1;
        for (int i = 0; i < count; i++)
        begin
            if (i % 100 == 0)
                fill_bias = 1'($urandom_range(0, 1));
            r = $urandom_range(0, 99);
            if (r < 4)
                f = cht_pkg::FUNC_NONE;
            else if (r < (fill_bias ? 60 : 25))
                f = cht_pkg::FUNC_INSERT;
            else if (r < (fill_bias ? 80 : 55))
                f = cht_pkg::FUNC_SEARCH;
            else
                f = cht_pkg::FUNC_REMOVE;
            if ($urandom_range(0, 9) == 0)
                k = cht_pkg::key_t'($urandom);
            else
                k = key_pool[$urandom_range(0, KEY_POOL - 1)];
            send_request(f, k, cht_pkg::value_t'($urandom));
        end
        wait_drain();
    endtask

    initial
    begin
        rst_n      <= 1'b0;
        start      <= 1'b0;
        func       <= cht_pkg::FUNC_NONE;
        key        <= '0;
        item_value <= '0;
        table_clear();
        // small keys collide in buckets, wide keys exercise the upper bits
        for (int i = 0; i < KEY_POOL; i++)
            key_pool[i] = (i < KEY_POOL / 2) ? cht_pkg::key_t'($urandom_range(0, 300))
                                             : cht_pkg::key_t'($urandom);
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_ops();
        test_pool_exhaust();
        test_random_mix(400, 0);
        test_random_mix(400, 58);
        test_random_mix(340, 17);
        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("Test completed with failures");
        $finish;
    end

endmodule
